// File: src/rrvm_pkg.sv
`timescale 1ns / 1ps
package rrvm_pkg;

  localparam int PHYS_W     = 52;
  localparam int PAGES_W    = 40;
  localparam int ATTR_W     = 64;
  localparam int ADDR_W     = 64;
  localparam int IDX_W      = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;

  localparam int PAGE_SHIFT = 12;
  localparam int G64K_BITS  = 16;
  localparam int G2M_BITS   = 21;
  localparam int RT_BIT     = 63;
  localparam int END_W      = PHYS_W + 1;

  localparam int MAX_REGIONS_DEF = 256;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [PHYS_W-1:0] VBASE_RESET = PHYS_W'(64'h4000_0000);
  localparam logic [ATTR_W-1:0] MASK_RESET  = 64'h8000_0000_0000_000F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VBASE_START = 1'b0,
    CFG_TYPE_MASK   = 1'b1
  } cfg_reg_t;

  // classified descriptor handed from front to back
  typedef struct packed {
    logic                 sof;
    logic                 mapped;
    logic                 new_run;
    logic                 big;
    logic [G64K_BITS-1:0] phys_low;
    logic [PHYS_W-1:0]    size;
    logic [IDX_W-1:0]     idx;
  } cmd_t;

  typedef struct packed {
    logic              is_runtime;
    logic [ADDR_W-1:0] vaddr;
    logic [IDX_W-1:0]  runtime_index;
  } result_t;

endpackage

// File: src/rrvm_fifo.sv
`timescale 1ns / 1ps
module rrvm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

// File: src/rrvm_front.sv
`timescale 1ns / 1ps
module rrvm_front
  import rrvm_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               start_of_map,
  input  logic [PHYS_W-1:0]  desc_base,
  input  logic [PAGES_W-1:0] page_count,
  input  logic [ATTR_W-1:0]  attributes,
  input  logic [ATTR_W-1:0]  type_match_mask,
  output cmd_t               cmd
);

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  logic [END_W-1:0]  prev_end_r;
  logic [ATTR_W-1:0] prev_attr_r;
  logic              prev_valid_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              pv;
  logic [CNT_W-1:0]  cnt;
  logic              adjacent, compatible, new_run, mapped;
  logic [PHYS_W-1:0] size;
  logic [END_W-1:0]  end_addr;

  always_comb begin
    pv         = start_of_map ? 1'b0 : prev_valid_r;
    cnt        = start_of_map ? '0 : count_r;
    size       = PHYS_W'(page_count) << PAGE_SHIFT;
    end_addr   = {1'b0, desc_base} + {1'b0, size};
    adjacent   = pv && (prev_end_r == {1'b0, desc_base});
    compatible = ((prev_attr_r ^ attributes) & type_match_mask) == '0;
    new_run    = !(adjacent && compatible);
    mapped     = attributes[RT_BIT] && (cnt < CNT_W'(MAX_REGIONS));
    count_nxt  = cnt + CNT_W'(mapped);

    cmd.sof      = start_of_map;
    cmd.mapped   = mapped;
    cmd.new_run  = new_run;
    // a 2 MiB aligned start has zero low bits, so only the page count decides the size test
    cmd.big      = (desc_base[G2M_BITS-1:0] == '0) &&
                   (page_count >= (PAGES_W'(1) << (G2M_BITS - PAGE_SHIFT)));
    cmd.phys_low = new_run ? desc_base[G64K_BITS-1:0] : '0;
    cmd.size     = size;
    cmd.idx      = mapped ? IDX_W'(cnt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
      count_r      <= '0;
    end else if (accept) begin
      prev_valid_r <= 1'b1;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_end_r  <= end_addr;
      prev_attr_r <= attributes;
    end
  end

endmodule

// File: src/rrvm_back.sv
`timescale 1ns / 1ps
module rrvm_back
  import rrvm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic [PHYS_W-1:0] virtual_base_start,
  input  logic              res_full,
  output logic              res_push,
  output result_t           res
);

  logic [ADDR_W-1:0] vbase_r, vbase_nxt;
  logic [ADDR_W-1:0] base, aligned, virt;
  logic              fire;

  assign fire     = cmd_valid && !res_full;
  assign cmd_pop  = fire;
  assign res_push = fire;

  always_comb begin
    base = cmd.sof ? ADDR_W'(virtual_base_start) : vbase_r;
    if (!cmd.new_run) begin
      aligned = base;
    end else if (cmd.big) begin
      aligned = {base[ADDR_W-1:G2M_BITS] + (ADDR_W - G2M_BITS)'(|base[G2M_BITS-1:0]),
                 {G2M_BITS{1'b0}}};
    end else begin
      aligned = {base[ADDR_W-1:G64K_BITS] + (ADDR_W - G64K_BITS)'(|base[G64K_BITS-1:0]),
                 {G64K_BITS{1'b0}}};
    end
    // low bits of aligned are zero on a new run, so the offset can be merged in
    virt      = aligned | ADDR_W'(cmd.phys_low);
    vbase_nxt = cmd.mapped ? virt + ADDR_W'(cmd.size) : base;

    res.is_runtime    = cmd.mapped;
    res.vaddr         = cmd.mapped ? virt : '0;
    res.runtime_index = cmd.idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbase_r <= ADDR_W'(VBASE_RESET);
    end else if (fire) begin
      vbase_r <= vbase_nxt;
    end
  end

endmodule

// File: src/runtime_region_virtual_mapper_top.sv
`timescale 1ns / 1ps
// Maps sorted memory-map descriptors to virtual addresses, one descriptor per clock sustained
// while results are popped. A descriptor pushed is classified at once (adjacency to the
// previous region, attribute match, runtime count) and queued in the command queue; the back
// end applies the running virtual base once the result queue has room, and the result is
// written to the result queue, from which it shows on the out_ ports. The rate is set by the
// running-base update in the back end, which rounds and adds combinationally. Two-entry
// queues sit between front and back and in front of the result ports, so full rises only
// once the result queue has filled, which needs a waiting result to go unpopped.
// Configuration writes take effect at once; write them only while the block is empty.
module runtime_region_virtual_mapper_top
  import rrvm_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_start_of_map,
  input  logic [PHYS_W-1:0]     in_phys_addr,
  input  logic [PAGES_W-1:0]    in_page_count,
  input  logic [ATTR_W-1:0]     in_attributes,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_is_runtime,
  output logic [ADDR_W-1:0]     out_virt_addr,
  output logic [IDX_W-1:0]      out_runtime_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PHYS_W-1:0] vbase_start_r;
  logic [ATTR_W-1:0] type_mask_r;

  cmd_t    front_cmd, head_cmd;
  result_t back_res, out_res;
  logic    accept, q_empty, q_pop, r_full, r_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbase_start_r <= VBASE_RESET;
      type_mask_r   <= MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VBASE_START: vbase_start_r <= cfg_data[PHYS_W-1:0];
        CFG_TYPE_MASK:   type_mask_r   <= cfg_data[ATTR_W-1:0];
        default:         ;
      endcase
    end
  end

  assign accept = in_push && !in_full;

  rrvm_front #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .start_of_map   (in_start_of_map),
    .desc_base      (in_phys_addr),
    .page_count     (in_page_count),
    .attributes     (in_attributes),
    .type_match_mask(type_mask_r),
    .cmd            (front_cmd)
  );

  rrvm_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push),
    .full (in_full),
    .din  (front_cmd),
    .pop  (q_pop),
    .empty(q_empty),
    .dout (head_cmd)
  );

  rrvm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (!q_empty),
    .cmd               (head_cmd),
    .cmd_pop           (q_pop),
    .virtual_base_start(vbase_start_r),
    .res_full          (r_full),
    .res_push          (r_push),
    .res               (back_res)
  );

  rrvm_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (r_push),
    .full (r_full),
    .din  (back_res),
    .pop  (out_pop),
    .empty(out_empty),
    .dout (out_res)
  );

  assign out_is_runtime    = out_res.is_runtime;
  assign out_virt_addr     = out_res.vaddr;
  assign out_runtime_index = out_res.runtime_index;

endmodule

// File: src/rrvm_checker.sv
`timescale 1ns / 1ps
module rrvm_checker
  import rrvm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_full,
  input logic                  out_empty,
  input logic                  out_pop,
  input logic                  out_is_runtime,
  input logic [ADDR_W-1:0]     out_virt_addr,
  input logic [IDX_W-1:0]      out_runtime_index
);

  // reset leaves both queues drained
  a_reset_drained: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not drained after reset");

  // a waiting result holds until popped
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_is_runtime) &&
      $stable(out_virt_addr) && $stable(out_runtime_index))
    else $error("waiting result changed before pop");

  // unmapped regions carry zero address and index
  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_is_runtime |-> out_virt_addr == '0 && out_runtime_index == '0)
    else $error("unmapped result carries nonzero fields");

  // full only comes while a result is waiting on the output
  a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(!out_empty))
    else $error("input full without a waiting result");

endmodule

bind runtime_region_virtual_mapper_top rrvm_checker u_rrvm_checker (.*);

// File: bench/rrvm_mapping_checker.sv
`timescale 1ns / 1ps
module rrvm_mapping_checker
  import rrvm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic                  in_start_of_map,
  input  logic [PHYS_W-1:0]     in_phys_addr,
  input  logic [PAGES_W-1:0]    in_page_count,
  input  logic [ATTR_W-1:0]     in_attributes,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic                  out_is_runtime,
  input  logic [ADDR_W-1:0]     out_virt_addr,
  input  logic [IDX_W-1:0]      out_runtime_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    outstanding,
  output int                    mapped_total,
  output int                    refused_total
);

  // register copies
  logic [PHYS_W-1:0] vbase_start;
  logic [ATTR_W-1:0] match_mask;

  // running map state
  logic [ADDR_W-1:0] vbase_run;
  logic [ADDR_W-1:0] prev_end;
  logic [ATTR_W-1:0] prev_attr;
  logic              have_prev;
  logic [8:0]        region_count;

  result_t pending_mappings[$];

  function automatic logic [ADDR_W-1:0] align_to(logic [ADDR_W-1:0] v, int bits);
    logic [ADDR_W-1:0] m;
    m = (64'd1 << bits) - 64'd1;
    return (v + m) & ~m;
  endfunction

  function automatic result_t map_descriptor(logic sof, logic [PHYS_W-1:0] phys,
                                             logic [PAGES_W-1:0] pages,
                                             logic [ATTR_W-1:0] attr);
    result_t           r;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] region_end;
    logic [ADDR_W-1:0] offset;
    logic              adjacent;
    logic              compatible;
    r          = '0;
    span       = {24'b0, pages} << PAGE_SHIFT;
    region_end = {12'b0, phys} + span;
    if (sof) begin
      vbase_run    = {12'b0, vbase_start};
      have_prev    = 1'b0;
      region_count = '0;
    end
    if (attr[RT_BIT] && region_count < MAX_REGIONS_DEF) begin
      adjacent   = have_prev && (prev_end == {12'b0, phys});
      compatible = ((prev_attr ^ attr) & match_mask) == '0;
      offset     = '0;
      if (!adjacent || !compatible) begin
        // new run: start drops to 64k, base rounds to 2m or 64k
        offset = {48'b0, phys[G64K_BITS-1:0]};
        span   = span + offset;
        if (phys[G2M_BITS-1:0] == '0 && span >= (64'd1 << G2M_BITS)) begin
          vbase_run = align_to(vbase_run, G2M_BITS);
        end else begin
          vbase_run = align_to(vbase_run, G64K_BITS);
        end
      end
      r.is_runtime    = 1'b1;
      r.vaddr         = vbase_run + offset;
      r.runtime_index = region_count[IDX_W-1:0];
      vbase_run       = vbase_run + span;
      region_count    = region_count + 9'd1;
      mapped_total++;
    end else if (attr[RT_BIT]) begin
      refused_total++;
    end
    prev_end  = region_end;
    prev_attr = attr;
    have_prev = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      vbase_start    = VBASE_RESET;
      match_mask     = MASK_RESET;
      vbase_run      = {12'b0, VBASE_RESET};
      prev_end       = '0;
      prev_attr      = '0;
      have_prev      = 1'b0;
      region_count   = '0;
      mismatch_count = 0;
      mapped_total   = 0;
      refused_total  = 0;
      pending_mappings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VBASE_START: vbase_start = cfg_data[PHYS_W-1:0];
          CFG_TYPE_MASK:   match_mask  = cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        pending_mappings.push_back(map_descriptor(in_start_of_map, in_phys_addr,
                                                  in_page_count, in_attributes));
      end
      if (out_pop && !out_empty) begin
        if (pending_mappings.size() == 0) begin
          $error("result popped with no descriptor request waiting");
          mismatch_count++;
        end else begin
          want = pending_mappings.pop_front();
          if (out_is_runtime !== want.is_runtime) begin
            $error("is_runtime: expected %0d, got %0d", want.is_runtime, out_is_runtime);
            mismatch_count++;
          end
          if (out_virt_addr !== want.vaddr) begin
            $error("out_virt_addr: expected %h, got %h", want.vaddr, out_virt_addr);
            mismatch_count++;
          end
          if (out_runtime_index !== want.runtime_index) begin
            $error("runtime_index: expected %0d, got %0d", want.runtime_index,
                   out_runtime_index);
            mismatch_count++;
          end
        end
      end
    end
    outstanding = pending_mappings.size();
  end

endmodule

// File: bench/runtime_region_virtual_mapper_top_tb.sv
`timescale 1ns / 1ps
module runtime_region_virtual_mapper_top_tb
  import rrvm_pkg::*;
();

  localparam int STALL_LIMIT = 1000;
  localparam logic [ATTR_W-1:0] RT = 64'h8000_0000_0000_0000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic                  in_start_of_map;
  logic [PHYS_W-1:0]     in_phys_addr;
  logic [PAGES_W-1:0]    in_page_count;
  logic [ATTR_W-1:0]     in_attributes;
  logic                  out_empty;
  logic                  out_pop;
  logic                  out_is_runtime;
  logic [ADDR_W-1:0]     out_virt_addr;
  logic [IDX_W-1:0]      out_runtime_index;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int outstanding;
  int mapped_total;
  int refused_total;

  int sent_count;
  int write_count;
  int send_streak;
  int recv_streak;
  int stall_cycles;
  logic [PHYS_W-1:0] cursor;

  runtime_region_virtual_mapper_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_start_of_map   (in_start_of_map),
    .in_phys_addr      (in_phys_addr),
    .in_page_count     (in_page_count),
    .in_attributes     (in_attributes),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_is_runtime    (out_is_runtime),
    .out_virt_addr     (out_virt_addr),
    .out_runtime_index (out_runtime_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  rrvm_mapping_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_start_of_map   (in_start_of_map),
    .in_phys_addr      (in_phys_addr),
    .in_page_count     (in_page_count),
    .in_attributes     (in_attributes),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_is_runtime    (out_is_runtime),
    .out_virt_addr     (out_virt_addr),
    .out_runtime_index (out_runtime_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .outstanding       (outstanding),
    .mapped_total      (mapped_total),
    .refused_total     (refused_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle cycles before the next request, with occasional back-to-back runs
  function automatic int draw_gap(inout int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      streak = $urandom_range(5, 20);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  task automatic send_desc(logic sof, logic [PHYS_W-1:0] phys, logic [PAGES_W-1:0] pages,
                           logic [ATTR_W-1:0] attr);
    int gap;
    gap = draw_gap(send_streak);
    repeat (gap) begin
      @(negedge clk);
      in_push = 1'b0;
    end
    @(negedge clk);
    in_push         = 1'b1;
    in_start_of_map = sof;
    in_phys_addr    = phys;
    in_page_count   = pages;
    in_attributes   = attr;
    do @(posedge clk); while (in_full);
    sent_count++;
  endtask

  // wait until every request has come back and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    in_push = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    write_count++;
  endtask

  task automatic send_map(int n, bit fresh, int rt_pct);
    logic [ATTR_W-1:0]  base_attr;
    logic [ATTR_W-1:0]  attr;
    logic [PHYS_W-1:0]  phys;
    logic [PAGES_W-1:0] pages;
    logic               rt;
    int                 r;
    base_attr = {$urandom, $urandom};
    base_attr[3:0] = 4'($urandom_range(0, 3));
    if (fresh) cursor = PHYS_W'($urandom_range(0, 255)) << G64K_BITS;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        phys = cursor;
      end else if (r < 80) begin
        phys = cursor + (PHYS_W'($urandom_range(1, 64)) << PAGE_SHIFT);
      end else if (r < 90) begin
        phys = (cursor + 52'h1F_FFFF) & ~52'h1F_FFFF;
      end else begin
        phys = PHYS_W'({$urandom, $urandom});
      end
      r = $urandom_range(0, 99);
      if (r < 50) pages = PAGES_W'($urandom_range(1, 32));
      else if (r < 70) pages = PAGES_W'(512 * $urandom_range(1, 4));
      else if (r < 78) pages = '0;
      else if (r < 92) pages = PAGES_W'($urandom_range(1, 4096));
      else pages = PAGES_W'({$urandom, $urandom});
      rt   = ($urandom_range(0, 99) < rt_pct);
      attr = base_attr;
      r    = $urandom_range(0, 99);
      if (r < 12) attr[$urandom_range(0, 3)] = ~attr[$urandom_range(0, 3)];
      else if (r < 18) attr[$urandom_range(4, 62)] = ~attr[$urandom_range(4, 62)];
      else if (r < 22) attr = {$urandom, $urandom};
      attr[RT_BIT] = rt;
      send_desc(fresh && i == 0, phys, pages, attr);
      cursor = phys + PHYS_W'({pages, 12'b0});
    end
  endtask

  // result side: random pops, two long hold-offs to back the block up
  initial begin
    int idle;
    int pops;
    pops = 0;
    wait (rst_n === 1'b1);
    forever begin
      idle = draw_gap(recv_streak);
      if (pops == 200 || pops == 300) idle = 64;
      repeat (idle) begin
        @(negedge clk);
        out_pop = 1'b0;
      end
      @(negedge clk);
      out_pop = 1'b1;
      do @(posedge clk); while (out_empty);
      pops++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("runtime_region_virtual_mapper_top test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_start_of_map = 1'b0;
    in_phys_addr    = '0;
    in_page_count   = '0;
    in_attributes   = '0;
    out_pop         = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_VBASE_START;
    cfg_data        = '0;
    sent_count      = 0;
    write_count     = 0;
    send_streak     = 0;
    recv_streak     = 0;
    stall_cycles    = 0;
    cursor          = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // no start of map yet: reset state, no previous region
    send_desc(1'b0, 52'h0, 40'h0, RT);
    send_desc(1'b0, 52'h0, 40'h1, RT);
    // adjacent but a masked attribute bit differs
    send_desc(1'b0, 52'h1000, 40'd512, RT | 64'h1);
    // plain descriptor still becomes the previous region
    send_desc(1'b0, 52'h20_1000, 40'd16, 64'h7);
    send_desc(1'b0, 52'h21_1000, 40'd4, RT | 64'h7);
    // difference outside the mask keeps the run going
    send_desc(1'b0, 52'h21_5000, 40'd2, RT | 64'h7 | (64'h1 << 40));
    send_desc(1'b0, 52'h40_0000, 40'd512, RT);
    send_desc(1'b0, 52'h80_0000, 40'd1, RT | 64'h2);
    send_desc(1'b0, 52'h80_3000, 40'd3, RT | 64'h3);
    send_desc(1'b0, 52'h123, 40'd5, RT);
    send_desc(1'b1, {PHYS_W{1'b1}}, {PAGES_W{1'b1}}, {ATTR_W{1'b1}});
    send_desc(1'b1, 52'h0, {PAGES_W{1'b1}}, RT);
    send_desc(1'b0, 52'h0, 40'h0, 64'h0);
    send_desc(1'b1, 52'hF_FFFF_FFE0_0000, 40'd512, RT);
    send_desc(1'b0, 52'h5_5555_5555_5000, 40'hAA_AAAA_AAAA, ~RT);
    send_desc(1'b0, 52'hA_AAAA_AAAA_A000, 40'h55_5555_5555, RT | 64'h5555_5555_5555_5555);

    // register change in the middle of a map
    settle();
    cfg_write(CFG_VBASE_START, 64'hFFF0_0000_0000_0000);
    cfg_write(CFG_TYPE_MASK, 64'h0);
    send_desc(1'b0, 52'h100_0000, 40'd8, RT);
    send_desc(1'b0, 52'h100_8000, 40'd8, RT | 64'hF);
    send_desc(1'b1, 52'h30_0000, 40'd600, RT);

    // zero base, nothing has to match
    for (int m = 0; m < 4; m++) send_map(15, 1'b1, 80);

    settle();
    cfg_write(CFG_VBASE_START, {CFG_DATA_W{1'b1}});
    cfg_write(CFG_TYPE_MASK, {CFG_DATA_W{1'b1}});
    for (int m = 0; m < 4; m++) send_map(15, 1'b1, 80);

    // one map long enough to run the region table full
    settle();
    cfg_write(CFG_VBASE_START, {12'($urandom), 52'h0_0000_4000_0000});
    cfg_write(CFG_TYPE_MASK, MASK_RESET);
    send_map(280, 1'b1, 100);

    settle();
    cfg_write(CFG_VBASE_START, {$urandom, $urandom});
    cfg_write(CFG_TYPE_MASK, {$urandom, $urandom});
    for (int m = 0; m < 3; m++) begin
      send_map(6, 1'b1, 70);
      settle();
      cfg_write(CFG_TYPE_MASK, {$urandom, $urandom});
      send_map(6, 1'b0, 70);
    end

    settle();
    cfg_write(CFG_VBASE_START, {$urandom, $urandom});
    cfg_write(CFG_TYPE_MASK, {1'b1, 59'($urandom), 4'hF});
    for (int m = 0; m < 3; m++) send_map(10, 1'b1, 75);

    @(negedge clk);
    in_push = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("sent %0d descriptors across %0d register writes", sent_count, write_count);
    $display("%0d runtime regions mapped, %0d turned away by a full table",
             mapped_total, refused_total);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("runtime_region_virtual_mapper_top test passed");
    end else begin
      $display("runtime_region_virtual_mapper_top test failed");
    end
    $finish;
  end

endmodule
